// ===== rtl/eos_pkg.sv =====
`timescale 1ns / 1ps

package eos_pkg;

    localparam int unsigned PtW        = 14;
    localparam int unsigned EtaW       = 13;
    localparam int unsigned AbsEtaThrW = 12;
    localparam int unsigned IsoW       = 18;
    localparam int unsigned MvaW       = 12;
    localparam int unsigned CountW     = 8;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 18;
    localparam int unsigned STdataW    = 80;
    localparam int unsigned MTdataW    = 40;

    localparam int unsigned CountLimitDefault = 255;

    // loose MVA working point, |eta| bin edges and score cuts at scale 1024
    localparam logic [EtaW-1:0]        EtaBin1Max = 13'd819;
    localparam logic [EtaW-1:0]        EtaBin2Max = 13'd1514;
    localparam logic signed [MvaW-1:0] MvaCutBin1 = -12'sd41;
    localparam logic signed [MvaW-1:0] MvaCutBin2 = 12'sd393;
    localparam logic signed [MvaW-1:0] MvaCutBin3 = -12'sd527;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PT_THR       = 3'd0,
        CFG_ABS_ETA_THR  = 3'd1,
        CFG_REL_ISO_THR  = 3'd2,
        CFG_MINI_ISO_THR = 3'd3,
        CFG_USE_MINI_ISO = 3'd4,
        CFG_USE_MVA_ID   = 3'd5,
        CFG_VETO_MODE    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [PtW-1:0]        pt_threshold;
        logic [AbsEtaThrW-1:0] abs_eta_threshold;
        logic [IsoW-1:0]       rel_iso_threshold;
        logic [IsoW-1:0]       mini_iso_threshold;
        logic                  use_mini_iso;
        logic                  use_mva_id;
        logic                  veto_mode;
    } cfg_t;

    typedef struct packed {
        logic                   has_electron;
        logic [PtW-1:0]         electron_pt;
        logic signed [EtaW-1:0] electron_eta;
        logic [IsoW-1:0]        rel_isolation;
        logic [IsoW-1:0]        mini_isolation;
        logic                   cut_id_pass;
        logic signed [MvaW-1:0] mva_score;
    } cand_t;

endpackage

// ===== rtl/eos_cand_cut.sv =====
`timescale 1ns / 1ps

module eos_cand_cut (
    input  eos_pkg::cand_t cand,
    input  eos_pkg::cfg_t  cfg,
    output logic           selected
);

    logic [eos_pkg::EtaW-1:0] abs_eta;
    logic                     mva_ok;
    logic                     id_ok;
    logic                     iso_ok;
    logic                     pt_ok;
    logic                     eta_ok;

    assign abs_eta = cand.electron_eta[eos_pkg::EtaW-1]
                   ? (~cand.electron_eta + 1'b1) : cand.electron_eta;

    always_comb begin
        if (abs_eta <= eos_pkg::EtaBin1Max) begin
            mva_ok = cand.mva_score >= eos_pkg::MvaCutBin1;
        end else if (abs_eta <= eos_pkg::EtaBin2Max) begin
            mva_ok = cand.mva_score >= eos_pkg::MvaCutBin2;
        end else begin
            mva_ok = cand.mva_score >= eos_pkg::MvaCutBin3;
        end
    end

    assign id_ok  = cfg.use_mva_id ? mva_ok : cand.cut_id_pass;
    assign iso_ok = cfg.use_mini_iso ? (cand.mini_isolation < cfg.mini_iso_threshold)
                                     : (cand.rel_isolation < cfg.rel_iso_threshold);
    assign pt_ok  = cand.electron_pt >= cfg.pt_threshold;
    assign eta_ok = abs_eta <= {1'b0, cfg.abs_eta_threshold};

    assign selected = cand.has_electron && pt_ok && eta_ok && id_ok && iso_ok;

endmodule

// ===== rtl/electron_object_selection_top.sv =====
`timescale 1ns / 1ps

// Electron selection over a stream of candidates, one candidate per transaction, events
// closed by s_tlast. Every input transaction yields exactly one output transaction: m_tuser
// flags a selected candidate, and on the last transaction of an event (m_tlast) m_tdata
// carries the verdict, the saturating selected count, the leading pt and its eta; otherwise
// m_tdata is zero. Throughput is one transaction per cycle unless m_tready stalls the output;
// each transaction passes through the input register, then the result register, with the
// per-event count and leader updated between them. Configuration writes are taken at any time
// on the cfg channel but must only be issued while no transaction is in flight.
module electron_object_selection_top #(
    parameter int unsigned COUNT_LIMIT = eos_pkg::CountLimitDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eos_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [eos_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // electron_pt, electron_eta, rel_isolation, mini_isolation, cut_id_pass, mva_score, pad
    input  logic [eos_pkg::STdataW-1:0]   s_tdata,
    input  logic                          s_tuser,  // has_electron
    input  logic                          s_tlast,  // last_of_event
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // event_passed, selected_count, leading_pt, leading_eta, pad
    output logic [eos_pkg::MTdataW-1:0]   m_tdata,
    output logic                          m_tuser,  // electron_selected
    output logic                          m_tlast   // event_done
);

    localparam logic [eos_pkg::CountW-1:0] CountCap =
        (COUNT_LIMIT < 255) ? eos_pkg::CountW'(COUNT_LIMIT) : 8'd255;

    eos_pkg::cfg_t cfg_reg, cfg_next;

    logic           in_valid_reg, in_valid_next;
    logic           in_last_reg;
    eos_pkg::cand_t in_cand_reg;
    eos_pkg::cand_t s_cand;

    logic [eos_pkg::CountW-1:0]    count_reg, count_next;
    logic [eos_pkg::PtW-1:0]       lead_pt_reg, lead_pt_next;
    logic signed [eos_pkg::EtaW-1:0] lead_eta_reg, lead_eta_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [eos_pkg::MTdataW-1:0]     m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                            out_free;
    logic                            adv;
    logic                            sel;
    logic [eos_pkg::CountW-1:0]      count_upd;
    logic [eos_pkg::PtW-1:0]         lead_pt_upd;
    logic signed [eos_pkg::EtaW-1:0] lead_eta_upd;
    logic                            event_passed;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (eos_pkg::cfg_idx_t'(cfg_index))
                eos_pkg::CFG_PT_THR:       cfg_next.pt_threshold = cfg_data[13:0];
                eos_pkg::CFG_ABS_ETA_THR:  cfg_next.abs_eta_threshold = cfg_data[11:0];
                eos_pkg::CFG_REL_ISO_THR:  cfg_next.rel_iso_threshold = cfg_data;
                eos_pkg::CFG_MINI_ISO_THR: cfg_next.mini_iso_threshold = cfg_data;
                eos_pkg::CFG_USE_MINI_ISO: cfg_next.use_mini_iso = cfg_data[0];
                eos_pkg::CFG_USE_MVA_ID:   cfg_next.use_mva_id = cfg_data[0];
                eos_pkg::CFG_VETO_MODE:    cfg_next.veto_mode = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pt_threshold       <= '0;
            cfg_reg.abs_eta_threshold  <= 12'd2560;
            cfg_reg.rel_iso_threshold  <= 18'd154;
            cfg_reg.mini_iso_threshold <= 18'd410;
            cfg_reg.use_mini_iso       <= 1'b0;
            cfg_reg.use_mva_id         <= 1'b0;
            cfg_reg.veto_mode          <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_cand.has_electron   = s_tuser;
    assign s_cand.electron_pt    = s_tdata[13:0];
    assign s_cand.electron_eta   = s_tdata[26:14];
    assign s_cand.rel_isolation  = s_tdata[44:27];
    assign s_cand.mini_isolation = s_tdata[62:45];
    assign s_cand.cut_id_pass    = s_tdata[63];
    assign s_cand.mva_score      = s_tdata[75:64];

    assign out_free      = !m_tvalid_reg || m_tready;
    assign adv           = in_valid_reg && out_free;
    assign s_tready      = !in_valid_reg || out_free;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cand_reg <= s_cand;
            in_last_reg <= s_tlast;
        end
    end

    eos_cand_cut u_cand_cut (
        .cand     (in_cand_reg),
        .cfg      (cfg_reg),
        .selected (sel)
    );

    always_comb begin
        count_upd    = count_reg;
        lead_pt_upd  = lead_pt_reg;
        lead_eta_upd = lead_eta_reg;
        if (sel) begin
            if (count_reg < CountCap) begin
                count_upd = count_reg + 1'b1;
            end
            if (in_cand_reg.electron_pt > lead_pt_reg) begin
                lead_pt_upd  = in_cand_reg.electron_pt;
                lead_eta_upd = in_cand_reg.electron_eta;
            end
        end
    end

    assign event_passed = cfg_reg.veto_mode ? (count_upd == '0) : (count_upd != '0);

    always_comb begin
        count_next    = count_reg;
        lead_pt_next  = lead_pt_reg;
        lead_eta_next = lead_eta_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (adv) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = sel;
            m_tlast_next  = in_last_reg;
            if (in_last_reg) begin
                m_tdata_next  = {4'd0, lead_eta_upd, lead_pt_upd, count_upd, event_passed};
                count_next    = '0;
                lead_pt_next  = '0;
                lead_eta_next = '0;
            end else begin
                m_tdata_next  = '0;
                count_next    = count_upd;
                lead_pt_next  = lead_pt_upd;
                lead_eta_next = lead_eta_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            lead_pt_reg  <= '0;
            lead_eta_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            lead_pt_reg  <= lead_pt_next;
            lead_eta_reg <= lead_eta_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_mid_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata == '0)
        else $error("event fields nonzero on a mid-event transaction");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg |=> count_reg == '0 && lead_pt_reg == '0 && lead_eta_reg == '0)
        else $error("event state not cleared after last transaction");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountCap)
        else $error("selected count above its cap");

    a_lead_eta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_pt_reg == '0 |-> lead_eta_reg == '0)
        else $error("leading eta set without a leading pt");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule
